// ===== design/adf_pkg.sv =====
// shared constants, types and helpers for the anchor detection filter
package adf_pkg;

    localparam int MAX_CLASSES = 128;
    localparam int MAX_MASKS   = 64;
    localparam int BOX_CHANS   = 4;

    localparam int VAL_W   = 32;
    localparam int CC_W    = $clog2(MAX_CLASSES + 1);
    localparam int MC_W    = $clog2(MAX_MASKS + 1);
    localparam int CLS_W   = $clog2(MAX_CLASSES);
    localparam int IDX_W   = $clog2(MAX_MASKS);
    localparam int POS_W   = $clog2(BOX_CHANS + MAX_CLASSES + MAX_MASKS + 1);
    localparam int LIM_W   = 17;

    localparam int OUT_DATA_W = 208;

    // register indexes on the configuration port
    localparam logic [1:0] REG_CLASS_COUNT = 2'd0;
    localparam logic [1:0] REG_MASK_COUNT  = 2'd1;
    localparam logic [1:0] REG_SCORE_LIMIT = 2'd2;

    localparam logic [7:0]       CLASS_COUNT_RST = 8'd80;
    localparam logic [6:0]       MASK_COUNT_RST  = 7'd32;
    localparam logic [LIM_W-1:0] SCORE_LIMIT_RST = 17'd16384;

    typedef struct packed {
        logic signed [VAL_W-1:0] left;
        logic signed [VAL_W-1:0] top;
        logic signed [VAL_W-1:0] right;
        logic signed [VAL_W-1:0] bottom;
    } t_corners;

    function automatic logic [CC_W-1:0] clamp_classes(input logic [7:0] v);
        logic [CC_W-1:0] r;
        if (v == 8'd0) begin
            r = CC_W'(1);
        end else if ({1'b0, v} > 9'(MAX_CLASSES)) begin
            r = CC_W'(MAX_CLASSES);
        end else begin
            r = CC_W'(v);
        end
        return r;
    endfunction

    function automatic logic [MC_W-1:0] clamp_masks(input logic [6:0] v);
        logic [MC_W-1:0] r;
        if (v == 7'd0) begin
            r = MC_W'(1);
        end else if ({1'b0, v} > 8'(MAX_MASKS)) begin
            r = MC_W'(MAX_MASKS);
        end else begin
            r = MC_W'(v);
        end
        return r;
    endfunction

    // box is usable when both maximum corners are positive and corners are ordered
    function automatic logic box_valid(input t_corners c);
        return (c.right > 0) && (c.bottom > 0) &&
               (c.left <= c.right) && (c.top <= c.bottom);
    endfunction

endpackage

// ===== design/adf_box.sv =====
// centre and size to saturated box corners
module adf_box (
    input  logic signed [adf_pkg::VAL_W-1:0] i_cx,
    input  logic signed [adf_pkg::VAL_W-1:0] i_cy,
    input  logic signed [adf_pkg::VAL_W-1:0] i_width,
    input  logic signed [adf_pkg::VAL_W-1:0] i_height,
    output adf_pkg::t_corners                o_corners
);
    import adf_pkg::*;

    logic signed [VAL_W-1:0] half_w;
    logic signed [VAL_W-1:0] half_h;
    logic signed [VAL_W:0]   sum_left;
    logic signed [VAL_W:0]   sum_top;
    logic signed [VAL_W:0]   sum_right;
    logic signed [VAL_W:0]   sum_bottom;

    function automatic logic signed [VAL_W-1:0] sat(input logic signed [VAL_W:0] v);
        logic signed [VAL_W-1:0] r;
        if (v[VAL_W] != v[VAL_W-1]) begin
            r = v[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    // arithmetic shift floors toward minus infinity
    assign half_w = i_width >>> 1;
    assign half_h = i_height >>> 1;

    assign sum_left   = (VAL_W+1)'(i_cx) - (VAL_W+1)'(half_w);
    assign sum_top    = (VAL_W+1)'(i_cy) - (VAL_W+1)'(half_h);
    assign sum_right  = (VAL_W+1)'(i_cx) + (VAL_W+1)'(half_w);
    assign sum_bottom = (VAL_W+1)'(i_cy) + (VAL_W+1)'(half_h);

    always_comb begin
        o_corners.left   = sat(sum_left);
        o_corners.top    = sat(sum_top);
        o_corners.right  = sat(sum_right);
        o_corners.bottom = sat(sum_bottom);
    end

endmodule

// ===== design/anchor_detection_filter_core.sv =====
// anchor decode: box corners, class argmax, score gate and mask coefficient results
//
// channel   | dir | tdata / tuser / tlast
// ----------+-----+------------------------------------------------------------
// s_axis    | in  | tdata[31:0] channel_value
// m_axis    | out | tdata: class_id, best_score, left, top, right, bottom,
//           |     |        coeff_index, coeff_value; tlast = last_coeff
// cfg       | in  | we, index (0 class_count, 1 mask_count, 2 score_limit), data
//
// one input beat per cycle while s_axis is ready; a kept anchor's mask beat shows up on m_axis
// in the cycle after it is taken, from a single output register.
// s_axis is ready whenever the output register is empty or being drained.
// reset clears the channel position, kept flag, output valid and corner store,
// and loads the register defaults.
module anchor_detection_filter_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [31:0]                        i_s_axis_tdata,   // [31:0] channel_value
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [6:0] class_id, [38:7] best_score, [70:39] left_edge, [102:71] top_edge,
    // [134:103] right_edge, [166:135] bottom_edge, [172:167] coeff_index,
    // [204:173] coeff_value, [207:205] zero
    output logic [adf_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    output logic                               o_m_axis_tlast,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_index,
    input  logic [adf_pkg::LIM_W-1:0]          i_cfg_data
);
    import adf_pkg::*;

    logic [7:0]       r_class_count;
    logic [6:0]       r_mask_count;
    logic [LIM_W-1:0] r_score_limit;

    logic [POS_W-1:0]        r_pos;
    logic signed [VAL_W-1:0] r_cx;
    logic signed [VAL_W-1:0] r_cy;
    logic signed [VAL_W-1:0] r_width;
    t_corners                r_corners;
    logic signed [VAL_W-1:0] r_best;
    logic [CLS_W-1:0]        r_class;
    logic                    r_kept;

    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data;
    logic                    r_out_last;

    logic [CC_W-1:0]         cc;
    logic [MC_W-1:0]         mc;
    logic [POS_W:0]          total;
    logic [POS_W:0]          class_end;
    logic [POS_W:0]          pos_next;
    logic                    in_accept;
    logic signed [VAL_W-1:0] value;
    logic                    is_box;
    logic                    is_class;
    logic                    past_end;
    logic [CLS_W-1:0]        class_idx;
    logic [IDX_W-1:0]        coeff_idx;
    logic                    take_new;
    logic signed [VAL_W-1:0] n_best;
    logic [CLS_W-1:0]        n_class;
    logic                    score_ok;
    logic                    emit;
    t_corners                box_corners;

    adf_box u_box (
        .i_cx      (r_cx),
        .i_cy      (r_cy),
        .i_width   (r_width),
        .i_height  (value),
        .o_corners (box_corners)
    );

    assign cc        = clamp_classes(r_class_count);
    assign mc        = clamp_masks(r_mask_count);
    assign total     = (POS_W+1)'(BOX_CHANS) + (POS_W+1)'(cc) + (POS_W+1)'(mc);
    assign class_end = (POS_W+1)'(BOX_CHANS) + (POS_W+1)'(cc);
    assign pos_next  = {1'b0, r_pos} + (POS_W+1)'(1);

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign value           = i_s_axis_tdata;

    assign past_end  = {1'b0, r_pos} >= total;
    assign is_box    = {1'b0, r_pos} < (POS_W+1)'(BOX_CHANS);
    assign is_class  = !is_box && ({1'b0, r_pos} < class_end);
    assign class_idx = CLS_W'(r_pos - POS_W'(BOX_CHANS));
    assign coeff_idx = IDX_W'(r_pos - POS_W'(BOX_CHANS) - POS_W'(cc));

    // strictly greater replaces, so ties keep the lower class
    assign take_new = (class_idx == '0) || (value > r_best);
    assign n_best   = take_new ? value : r_best;
    assign n_class  = take_new ? class_idx : r_class;
    assign score_ok = (VAL_W+1)'(n_best) >= $signed({{(VAL_W+1-LIM_W){1'b0}}, r_score_limit});

    assign emit = in_accept && !past_end && !is_box && !is_class && r_kept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_count <= CLASS_COUNT_RST;
            r_mask_count  <= MASK_COUNT_RST;
            r_score_limit <= SCORE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CLASS_COUNT: r_class_count <= i_cfg_data[7:0];
                REG_MASK_COUNT:  r_mask_count  <= i_cfg_data[6:0];
                REG_SCORE_LIMIT: r_score_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_kept    <= 1'b0;
            r_corners <= '0;
            r_best    <= '0;
            r_class   <= '0;
        end else if (in_accept) begin
            if (past_end || pos_next >= total) begin
                r_pos <= '0;
            end else begin
                r_pos <= pos_next[POS_W-1:0];
            end

            if (past_end || pos_next >= total) begin
                r_kept <= 1'b0;
            end else if (is_box) begin
                r_kept <= 1'b0;
            end else if (is_class && ({1'b0, class_idx} == CC_W'(cc - CC_W'(1)))) begin
                r_kept <= box_valid(r_corners) && score_ok;
            end

            if (!past_end && is_box && r_pos[1:0] == 2'd3) begin
                r_corners <= box_corners;
            end

            if (!past_end && is_class) begin
                r_best  <= n_best;
                r_class <= n_class;
            end
        end
    end

    // centre and width are only needed until the height beat arrives
    always_ff @(posedge i_clk) begin
        if (in_accept && !past_end && is_box) begin
            case (r_pos[1:0])
                2'd0:    r_cx    <= value;
                2'd1:    r_cy    <= value;
                2'd2:    r_width <= value;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= {3'b000, value, coeff_idx,
                           r_corners.bottom, r_corners.right,
                           r_corners.top, r_corners.left,
                           r_best, r_class};
            r_out_last <= ({1'b0, coeff_idx} == MC_W'(mc - MC_W'(1)));
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== bench/anchor_detection_filter_core_test.sv =====
// self-checking testbench for the anchor detection filter core
`timescale 1ns / 100ps

module anchor_detection_filter_core_test;

    import adf_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int SHAPE_CC [8] = '{3, 1, 0, 6, 128, 2, 255, 12};
    localparam int SHAPE_MC [8] = '{2, 1, 0, 4, 64, 7, 127, 3};

    typedef struct {
        logic [6:0]  class_id;
        logic [31:0] best_score;
        logic [31:0] left_edge;
        logic [31:0] top_edge;
        logic [31:0] right_edge;
        logic [31:0] bottom_edge;
        logic [5:0]  coeff_index;
        logic [31:0] coeff_value;
        logic        last_coeff;
    } t_det;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [31:0]           s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;
    logic                  m_last;
    logic                  cfg_we    = 1'b0;
    logic [1:0]            cfg_index = REG_CLASS_COUNT;
    logic [LIM_W-1:0]      cfg_data  = '0;

    // predictor copy of the registers and of the anchor state
    logic [7:0]         cc_reg  = 8'd80;
    logic [6:0]         mc_reg  = 7'd32;
    logic [16:0]        lim_reg = 17'd16384;
    int                 chan_pos = 0;
    logic signed [31:0] box_raw [4] = '{default: '0};
    logic signed [31:0] left_x   = '0;
    logic signed [31:0] top_y    = '0;
    logic signed [31:0] right_x  = '0;
    logic signed [31:0] bottom_y = '0;
    bit                 box_good    = 1'b0;
    logic signed [31:0] lead_score  = '0;
    int                 lead_class  = 0;
    bit                 anchor_keep = 1'b0;

    t_det        pending_dets [$];
    t_det        want;
    logic [31:0] recent_score  = '0;
    bit          steady        = 1'b0;
    int          beats_sent    = 0;
    int          beats_checked = 0;
    int          reg_writes    = 0;
    int          mismatches    = 0;
    int          cycle_count   = 0;

    anchor_detection_filter_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge i_clk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 35);
    end

    function automatic int class_span();
        int r;
        r = cc_reg;
        if (r == 0) r = 1;
        if (r > MAX_CLASSES) r = MAX_CLASSES;
        return r;
    endfunction

    function automatic int mask_span();
        int r;
        r = mc_reg;
        if (r == 0) r = 1;
        if (r > MAX_MASKS) r = MAX_MASKS;
        return r;
    endfunction

    function automatic logic [31:0] clip32(input longint x);
        if (x > 64'sd2147483647) return 32'h7fff_ffff;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    // advance the anchor state by one channel; returns 1 when a detection beat is due
    function automatic bit decode_channel(input logic [31:0] raw, output t_det d);
        int                 cls_n, msk_n, total, p, c, j;
        longint             hw, hh;
        logic signed [31:0] v;
        bit                 made;
        cls_n = class_span();
        msk_n = mask_span();
        total = 4 + cls_n + msk_n;
        p     = chan_pos;
        v     = raw;
        made  = 1'b0;
        d     = '{default: '0};
        if (p >= total) begin
            // position left past the end by a register change
            chan_pos    = 0;
            anchor_keep = 1'b0;
            return 1'b0;
        end
        if (p < 4) begin
            box_raw[p]  = v;
            anchor_keep = 1'b0;
            if (p == 3) begin
                hw       = longint'(box_raw[2]) >>> 1;
                hh       = longint'(v) >>> 1;
                left_x   = clip32(longint'(box_raw[0]) - hw);
                top_y    = clip32(longint'(box_raw[1]) - hh);
                right_x  = clip32(longint'(box_raw[0]) + hw);
                bottom_y = clip32(longint'(box_raw[1]) + hh);
                box_good = !(right_x <= 0 || bottom_y <= 0 ||
                             left_x > right_x || top_y > bottom_y);
            end
        end else if (p < 4 + cls_n) begin
            c = p - 4;
            if (c == 0 || v > lead_score) begin
                lead_score = v;
                lead_class = c;
            end
            if (c == cls_n - 1) begin
                anchor_keep = box_good && (longint'(lead_score) >= longint'(lim_reg));
            end
        end else begin
            j = p - 4 - cls_n;
            if (anchor_keep) begin
                d.class_id    = 7'(lead_class);
                d.best_score  = lead_score;
                d.left_edge   = left_x;
                d.top_edge    = top_y;
                d.right_edge  = right_x;
                d.bottom_edge = bottom_y;
                d.coeff_index = 6'(j);
                d.coeff_value = v;
                d.last_coeff  = (j == msk_n - 1);
                made          = 1'b1;
            end
        end
        if (p + 1 >= total) begin
            chan_pos    = 0;
            anchor_keep = 1'b0;
        end else begin
            chan_pos = p + 1;
        end
        return made;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %h, got %h", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_dets.size() == 0) begin
                $error("detection beat with nothing expected: %h", m_data);
                mismatches++;
            end else begin
                want = pending_dets.pop_front();
                check_field("class_id",    32'(want.class_id),    32'(m_data[6:0]));
                check_field("best_score",  want.best_score,       m_data[38:7]);
                check_field("left_edge",   want.left_edge,        m_data[70:39]);
                check_field("top_edge",    want.top_edge,         m_data[102:71]);
                check_field("right_edge",  want.right_edge,       m_data[134:103]);
                check_field("bottom_edge", want.bottom_edge,      m_data[166:135]);
                check_field("coeff_index", 32'(want.coeff_index), 32'(m_data[172:167]));
                check_field("coeff_value", want.coeff_value,      m_data[204:173]);
                check_field("last_coeff",  32'(want.last_coeff),  32'(m_last));
                beats_checked++;
            end
        end
    end

    task automatic push_channel(input logic [31:0] value);
        t_det d;
        while (!steady && $urandom_range(0, 99) < 35) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= value;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        if (decode_channel(value, d)) pending_dets = {pending_dets, d};
        beats_sent++;
    endtask

    // registers change only once the output side has drained
    task automatic write_register(input logic [1:0] idx, input logic [16:0] value);
        s_valid <= 1'b0;
        while (pending_dets.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            REG_CLASS_COUNT: cc_reg  = value[7:0];
            REG_MASK_COUNT:  mc_reg  = value[6:0];
            REG_SCORE_LIMIT: lim_reg = value;
            default: ;
        endcase
        cfg_we <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_shape(input int cc, input int mc, input logic [16:0] lim);
        write_register(REG_CLASS_COUNT, 17'(cc));
        write_register(REG_MASK_COUNT, 17'(mc));
        write_register(REG_SCORE_LIMIT, lim);
    endtask

    // scores cluster around the limit, with repeats to make ties
    function automatic logic [31:0] draw_score();
        logic [31:0] s;
        case ($urandom_range(0, 7))
            0: s = $urandom();
            1: s = 32'(lim_reg);
            2: s = 32'(lim_reg) - 32'd1;
            3: s = recent_score;
            default: s = 32'(int'(lim_reg) + int'($urandom_range(0, 131072)) - 65536);
        endcase
        recent_score = s;
        return s;
    endfunction

    function automatic logic [31:0] extreme_value();
        case ($urandom_range(0, 4))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h0000_0001;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    task automatic send_anchor(input bit cut_short);
        logic [31:0] vals [$];
        logic [31:0] cx, cy, w, h;
        int          total, stop_at, k;
        // finish off any partial anchor so this one starts aligned
        while (chan_pos != 0) push_channel($urandom());
        total = 4 + class_span() + mask_span();
        cx = $urandom_range(0, 32'h0500_0000);
        cy = $urandom_range(0, 32'h0500_0000);
        w  = $urandom_range(0, 32'h0200_0000);
        h  = $urandom_range(0, 32'h0200_0000);
        case ($urandom_range(0, 9))
            7: begin
                cx = $urandom();
                cy = $urandom();
                w  = $urandom();
                h  = $urandom();
            end
            8: begin
                cx = extreme_value();
                cy = extreme_value();
                w  = extreme_value();
                h  = extreme_value();
            end
            9: w = -32'($urandom_range(1, 32'h0010_0000));
            default: ;
        endcase
        vals = {vals, cx};
        vals = {vals, cy};
        vals = {vals, w};
        vals = {vals, h};
        for (k = 0; k < class_span(); k++) vals = {vals, draw_score()};
        for (k = 0; k < mask_span(); k++) vals = {vals, 32'($urandom())};
        stop_at = cut_short ? $urandom_range(0, total - 1) : total;
        for (k = 0; k < stop_at; k++) push_channel(vals[k]);
    endtask

    task automatic test_register_defaults();
        send_anchor(1'b0);
    endtask

    task automatic test_saturated_box();
        set_shape(2, 2, 17'd65536);
        repeat (4) push_channel(32'h7fff_ffff);
        // equal scores: lower class wins
        push_channel(32'h7fff_ffff);
        push_channel(32'h7fff_ffff);
        push_channel(32'h8000_0000);
        push_channel(32'h0000_0001);
    endtask

    task automatic test_inverted_box();
        push_channel(32'h0064_0000);
        push_channel(32'h0064_0000);
        push_channel(32'hffff_fffc);
        push_channel(32'h0010_0000);
        push_channel(32'h0002_0000);
        push_channel(32'h0000_0000);
        push_channel(32'hffff_ffff);
        push_channel(32'h1234_5678);
    endtask

    task automatic test_score_at_limit();
        // box touching the origin on the left, zero height one lsb above it
        push_channel(32'h0010_0000);
        push_channel(32'h0000_0001);
        push_channel(32'h0020_0000);
        push_channel(32'h0000_0001);
        push_channel(32'h0000_ffff);
        push_channel(32'h0001_0000);
        push_channel(32'h0000_0000);
        push_channel(32'h7fff_ffff);
    endtask

    task automatic test_past_end();
        push_channel(32'h0010_0000);
        push_channel(32'h0010_0000);
        push_channel(32'h0004_0000);
        push_channel(32'h0004_0000);
        push_channel(32'h0003_0000);
        push_channel(32'h0003_0000);
        // shrink the anchor under the current position; next beat is dropped
        set_shape(1, 1, 17'd0);
        push_channel(32'h5555_aaaa);
        send_anchor(1'b0);
    endtask

    task automatic test_random_anchors();
        int          phase, sel, cc, mc, base, start;
        logic [16:0] lim;
        bit          big;
        phase = 0;
        base  = beats_sent;
        while (beats_sent - base < RANDOM_ITEMS) begin
            sel = phase % 8;
            cc  = SHAPE_CC[sel];
            mc  = SHAPE_MC[sel];
            if (phase >= 8 && (sel == 4 || sel == 6)) begin
                cc = $urandom_range(1, 20);
                mc = $urandom_range(1, 10);
            end
            case (phase % 4)
                0: lim = 17'($urandom_range(0, 131071));
                1: lim = 17'd0;
                2: lim = 17'd65536;
                default: lim = 17'h1ffff;
            endcase
            set_shape(cc, mc, lim);
            big    = (class_span() + mask_span() > 100);
            steady = (sel == 2);
            start  = beats_sent;
            do begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 6)) push_channel($urandom());
                end
                send_anchor(1'b0);
            end while (!big && beats_sent - start < 150 && beats_sent - base < RANDOM_ITEMS);
            // leave the anchor unfinished so the next register writes land mid-anchor
            send_anchor(1'b1);
            steady = 1'b0;
            phase++;
        end
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("anchor_detection_filter_core_test NOT OK");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_register_defaults();
        test_saturated_box();
        test_inverted_box();
        test_score_at_limit();
        test_past_end();
        test_random_anchors();
        s_valid <= 1'b0;
        while (pending_dets.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("sent %0d channel beats, checked %0d detection beats, %0d register writes",
                 beats_sent, beats_checked, reg_writes);
        $display("covered saturated and rejected boxes, score ties and limits, mid-anchor changes");
        if (mismatches == 0) begin
            $display("anchor_detection_filter_core_test OK");
        end else begin
            $display("anchor_detection_filter_core_test NOT OK");
        end
        $finish;
    end

endmodule
